// File: rtl/core/sbb_pkg.sv
`timescale 1ns / 1ps

package sbb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 15;
    localparam int TAPS       = 2 * MAX_RADIUS + 1;

    localparam int DIM_W    = 11;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int SLOT_W   = $clog2(TAPS);
    localparam int RAD_W    = 4;
    localparam int PIX_W    = 8;
    localparam int CH_N     = 3;
    localparam int SUM_W    = PIX_W + SLOT_W;
    localparam int STEP_W   = $clog2(SUM_W);
    localparam int CFG_IDX_W = 2;
    localparam int STORE_AW = SLOT_W + COL_W;
    localparam int RGB_W    = CH_N * PIX_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [CH_N-1:0][PIX_W-1:0] rgb_t;
    typedef logic [CH_N-1:0][SUM_W-1:0] sum_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HSUM,
        S_HDIV_GO,
        S_HDIV_WAIT,
        S_VCHK,
        S_VSUM,
        S_VDIV_GO,
        S_VDIV_WAIT,
        S_EMIT
    } state_t;

    function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] base,
                                                   input logic [SLOT_W-1:0] d);
        logic [SLOT_W:0] s;
        s = {1'b0, base} + (SLOT_W+1)'(TAPS) - {1'b0, d};
        if (s >= (SLOT_W+1)'(TAPS))
        begin
            s = s - (SLOT_W+1)'(TAPS);
        end
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(TAPS - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

// File: rtl/core/sbb_ram.sv
`timescale 1ns / 1ps

module sbb_ram #(
    parameter int ADDR_W = 5,
    parameter int DATA_W = 24
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/sbb_div.sv
`timescale 1ns / 1ps

module sbb_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sbb_pkg::SLOT_W-1:0]   divisor,
    input  sbb_pkg::sum_t                dividend,
    output logic                         done,
    output sbb_pkg::rgb_t                quotient
);

    import sbb_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    sum_t              num_reg;
    logic [CH_N-1:0][SLOT_W-1:0] rem_reg;
    sum_t              num_next;
    logic [CH_N-1:0][SLOT_W-1:0] rem_next;
    logic [SLOT_W:0]   trial;

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < CH_N; i++)
        begin
            trial = {rem_reg[i], num_reg[i][SUM_W-1]};
            if (trial >= {1'b0, divisor})
            begin
                rem_next[i] = SLOT_W'(trial - {1'b0, divisor});
                num_next[i] = {num_reg[i][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[SLOT_W-1:0];
                num_next[i] = {num_reg[i][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < CH_N; i++)
        begin
            quotient[i] = num_reg[i][PIX_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

// File: rtl/core/separable_box_blur_top.sv
`timescale 1ns / 1ps

// Separable box blur over an RGB raster stream, one pixel per input transaction. Each channel
// gets a horizontal floor mean over 2r+1 pixels, then a vertical floor mean of those bytes over
// 2r+1 rows; samples outside the frame count as zero. In filtering mode results trail inputs by
// r rows plus r pixels, so the host follows each frame with r*image_width+r flush transactions
// of any content. A radius of zero, or one above image_width/2-1 or image_height/2-1, passes
// pixels straight through. A write to the width, height or radius register restarts the frame.
// One item is processed at a time: a pass-through item goes straight to output; a filtered item
// sums taps and divides for each horizontal mean it completes (one per pixel from column r, r+1
// at a row's end) and its vertical mean, paced by the single read ports of line store and
// window and the 13-step shared divider. The next item is taken while a result waits on output.
module separable_box_blur_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      red_in,
    input  logic [7:0]                      green_in,
    input  logic [7:0]                      blue_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      red_out,
    output logic [7:0]                      green_out,
    output logic [7:0]                      blue_out,
    output logic                            frame_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbb_pkg::DIM_W-1:0]       cfg_data
);

    import sbb_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [DIM_W-1:0]  w_reg;
    logic [DIM_W-1:0]  h_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic              filt;
    logic [SLOT_W-1:0] two_r;
    logic [SLOT_W-1:0] div_d;
    logic [DIM_W-1:0]  rad_ext;

    logic [DIM_W-1:0]  col_reg;
    logic [DIM_W-1:0]  row_reg;
    logic [SLOT_W-1:0] col_mod_reg;
    logic [SLOT_W-1:0] row_mod_reg;
    logic [DIM_W-1:0]  oc_reg;
    logic [DIM_W-1:0]  or_reg;
    logic [SLOT_W-1:0] or_mod_reg;

    logic [DIM_W-1:0]  x_reg;
    logic [SLOT_W-1:0] off_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic signed [DIM_W:0] pos_reg;
    logic [SLOT_W-1:0] cnt_reg;
    logic              rd_v_reg;
    logic              inc_reg;
    sum_t              sum_reg;
    rgb_t              res_reg;
    logic              last_reg;
    logic              out_valid_reg;
    rgb_t              out_pix_reg;
    logic              out_last_reg;

    logic              acc_in;
    logic              cfg_hit;
    logic              out_free;
    logic              due;
    logic              more;
    logic              adv;
    logic              div_start;
    logic              div_done;
    rgb_t              div_q;
    rgb_t              in_pix;
    logic [RGB_W-1:0]  win_q;
    logic [RGB_W-1:0]  st_q;
    rgb_t              rd_data;
    logic [DIM_W-1:0]  limit;
    logic [SLOT_W-1:0] off_dec;

    assign w_eff = (w_reg == '0) ? DIM_W'(1) :
                   (w_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_reg;
    assign h_eff = (h_reg == '0) ? DIM_W'(1) :
                   (h_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_reg;
    assign rad_ext = DIM_W'(rad_reg);
    assign filt  = (rad_reg != '0) && (rad_ext + 1'b1 <= (w_eff >> 1))
                   && (rad_ext + 1'b1 <= (h_eff >> 1));
    assign two_r = {rad_reg, 1'b0};
    assign div_d = {rad_reg, 1'b1};
    assign off_dec = off_reg - 1'b1;

    assign in_stall  = (state_reg != S_IDLE);
    assign acc_in    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && cfg_ready && (cfg_index == REG_IMAGE_WIDTH ||
                       cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_RADIUS);
    assign out_free  = !out_valid_reg || !out_stall;
    assign due       = (row_reg > rad_ext) || (row_reg == rad_ext && col_reg >= rad_ext);
    assign more      = (col_reg == w_eff - 1'b1) && (x_reg != w_eff - 1'b1);
    assign adv       = (state_reg == S_EMIT && out_free) || (state_reg == S_VCHK && !due);
    assign in_pix    = {blue_in, green_in, red_in};
    assign rd_data   = (state_reg == S_HSUM) ? rgb_t'(win_q) : rgb_t'(st_q);
    assign limit     = (state_reg == S_HSUM) ? w_eff : h_eff;

    sbb_ram #(
        .ADDR_W (SLOT_W),
        .DATA_W (RGB_W)
    ) u_window (
        .clk   (clk),
        .we    (acc_in && filt && (row_reg < h_eff)),
        .waddr (col_mod_reg),
        .wdata (in_pix),
        .raddr (slot_reg),
        .rdata (win_q)
    );

    sbb_ram #(
        .ADDR_W (STORE_AW),
        .DATA_W (RGB_W)
    ) u_store (
        .clk   (clk),
        .we    (state_reg == S_HDIV_WAIT && div_done),
        .waddr ({row_mod_reg, x_reg[COL_W-1:0]}),
        .wdata (div_q),
        .raddr ({slot_reg, oc_reg[COL_W-1:0]}),
        .rdata (st_q)
    );

    sbb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (div_d),
        .dividend (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc_in)
                begin
                    if (!filt)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (row_reg < h_eff && col_reg >= rad_ext)
                    begin
                        state_next = S_HSUM;
                    end
                    else
                    begin
                        state_next = S_VCHK;
                    end
                end
            end
            S_HSUM:
            begin
                if (cnt_reg == div_d && !rd_v_reg)
                begin
                    state_next = S_HDIV_GO;
                end
            end
            S_HDIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_HDIV_WAIT;
            end
            S_HDIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = more ? S_HSUM : S_VCHK;
                end
            end
            S_VCHK:
            begin
                state_next = due ? S_VSUM : S_IDLE;
            end
            S_VSUM:
            begin
                if (cnt_reg == div_d && !rd_v_reg)
                begin
                    state_next = S_VDIV_GO;
                end
            end
            S_VDIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_VDIV_WAIT;
            end
            S_VDIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration, frame position, read-valid flag and output valid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= DIM_W'(MAX_WIDTH);
            h_reg         <= DIM_W'(MAX_HEIGHT);
            rad_reg       <= RAD_W'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            col_mod_reg   <= '0;
            row_mod_reg   <= '0;
            oc_reg        <= '0;
            or_reg        <= '0;
            or_mod_reg    <= '0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  w_reg   <= cfg_data;
                    REG_IMAGE_HEIGHT: h_reg   <= cfg_data;
                    REG_RADIUS:       rad_reg <= cfg_data[RAD_W-1:0];
                    default:          ;
                endcase
            end

            if (cfg_hit || (adv && state_reg == S_EMIT && last_reg))
            begin
                col_reg     <= '0;
                row_reg     <= '0;
                col_mod_reg <= '0;
                row_mod_reg <= '0;
                oc_reg      <= '0;
                or_reg      <= '0;
                or_mod_reg  <= '0;
            end
            else if (adv)
            begin
                if (col_reg == w_eff - 1'b1)
                begin
                    col_reg     <= '0;
                    col_mod_reg <= '0;
                    row_reg     <= row_reg + 1'b1;
                    row_mod_reg <= slot_inc(row_mod_reg);
                end
                else
                begin
                    col_reg     <= col_reg + 1'b1;
                    col_mod_reg <= slot_inc(col_mod_reg);
                end
                if (state_reg == S_EMIT && filt)
                begin
                    if (oc_reg == w_eff - 1'b1)
                    begin
                        oc_reg     <= '0;
                        or_reg     <= or_reg + 1'b1;
                        or_mod_reg <= slot_inc(or_mod_reg);
                    end
                    else
                    begin
                        oc_reg <= oc_reg + 1'b1;
                    end
                end
            end

            if ((state_reg == S_HSUM || state_reg == S_VSUM) && cnt_reg != div_d)
            begin
                rd_v_reg <= 1'b1;
            end
            else
            begin
                rd_v_reg <= 1'b0;
            end

            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-item datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && acc_in)
        begin
            res_reg  <= in_pix;
            last_reg <= (row_reg == h_eff - 1'b1) && (col_reg == w_eff - 1'b1);
            x_reg    <= col_reg - rad_ext;
            off_reg  <= two_r;
            slot_reg <= slot_sub(col_mod_reg, two_r);
            pos_reg  <= $signed({1'b0, col_reg}) - $signed((DIM_W+1)'(two_r));
            cnt_reg  <= '0;
            sum_reg  <= '0;
        end

        if (state_reg == S_HDIV_WAIT && div_done && more)
        begin
            x_reg    <= x_reg + 1'b1;
            off_reg  <= off_dec;
            slot_reg <= slot_sub(col_mod_reg, off_dec);
            pos_reg  <= $signed({1'b0, col_reg}) - $signed((DIM_W+1)'(off_dec));
            cnt_reg  <= '0;
            sum_reg  <= '0;
        end

        if (state_reg == S_VCHK && due)
        begin
            slot_reg <= slot_sub(or_mod_reg, SLOT_W'(rad_reg));
            pos_reg  <= $signed({1'b0, or_reg}) - $signed((DIM_W+1)'(rad_reg));
            cnt_reg  <= '0;
            sum_reg  <= '0;
        end

        if (state_reg == S_HSUM || state_reg == S_VSUM)
        begin
            if (cnt_reg != div_d)
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                slot_reg <= slot_inc(slot_reg);
                pos_reg  <= pos_reg + 1'b1;
                inc_reg  <= !pos_reg[DIM_W] && (pos_reg < $signed({1'b0, limit}));
            end
            if (rd_v_reg && inc_reg)
            begin
                for (int i = 0; i < CH_N; i++)
                begin
                    sum_reg[i] <= sum_reg[i] + SUM_W'(rd_data[i]);
                end
            end
        end

        if (state_reg == S_VDIV_WAIT && div_done)
        begin
            res_reg  <= div_q;
            last_reg <= (or_reg == h_eff - 1'b1) && (oc_reg == w_eff - 1'b1);
        end

        if (state_reg == S_EMIT && out_free)
        begin
            out_pix_reg  <= res_reg;
            out_last_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = out_pix_reg[0];
    assign green_out  = out_pix_reg[1];
    assign blue_out   = out_pix_reg[2];
    assign frame_last = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HSUM || state_reg == S_VSUM) |-> cnt_reg <= div_d)
        else $error("tap counter past window");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_HDIV_WAIT || state_reg == S_VDIV_WAIT))
        else $error("divider result with no waiting mean");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < w_eff)
        else $error("column position beyond row");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_mod_reg < SLOT_W'(TAPS) && or_mod_reg < SLOT_W'(TAPS))
        else $error("row slot beyond line store");

endmodule

// File: tb/separable_box_blur_checker.sv
`timescale 1ns / 1ps

module separable_box_blur_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [7:0]                    red_in,
    input  logic [7:0]                    green_in,
    input  logic [7:0]                    blue_in,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [7:0]                    red_out,
    input  logic [7:0]                    green_out,
    input  logic [7:0]                    blue_out,
    input  logic                          frame_last,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [sbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbb_pkg::DIM_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            pending
);
    import sbb_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } blurred_pixel_t;

    blurred_pixel_t blurred_q[$];

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [RAD_W-1:0] radius_reg;
    logic [7:0]       row_window[TAPS][CH_N];
    logic [7:0]       row_means[TAPS][MAX_WIDTH][CH_N];
    int               col_pos;
    int               row_pos;

    assign pending = blurred_q.size();

    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    task automatic store_mean(input int y, input int x, input int w, input int r);
        int sum;
        int idx;
        for (int ch = 0; ch < CH_N; ch++)
        begin
            sum = 0;
            for (int k = 0; k <= 2 * r; k++)
            begin
                idx = x + k - r;
                if (idx >= 0 && idx < w)
                    sum += row_window[idx % TAPS][ch];
            end
            row_means[y % TAPS][x][ch] = 8'(sum / (2 * r + 1));
        end
    endtask

    task automatic blur_pixel(input logic [7:0] pix[CH_N]);
        int w;
        int h;
        int r;
        int t;
        int lag;
        int p;
        int i;
        int j;
        int sum;
        int total;
        bit filtering;
        blurred_pixel_t e;
        logic [7:0] res[CH_N];
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        r = radius_reg;
        filtering = r >= 1 && r <= MAX_RADIUS && r + 1 <= w / 2 && r + 1 <= h / 2;
        t = row_pos * w + col_pos;
        lag = r * w + r;
        total = filtering ? w * h + lag : w * h;
        if (!filtering)
        begin
            e.red = pix[0];
            e.green = pix[1];
            e.blue = pix[2];
            e.last = (t == w * h - 1);
            blurred_q.push_back(e);
        end
        else
        begin
            if (row_pos < h)
            begin
                for (int ch = 0; ch < CH_N; ch++)
                    row_window[col_pos % TAPS][ch] = pix[ch];
                if (col_pos >= r)
                    store_mean(row_pos, col_pos - r, w, r);
                if (col_pos == w - 1)
                    for (int x = w - r; x < w; x++)
                        store_mean(row_pos, x, w, r);
            end
            if (t >= lag)
            begin
                p = t - lag;
                i = p / w;
                j = p % w;
                for (int ch = 0; ch < CH_N; ch++)
                begin
                    sum = 0;
                    for (int k = 0; k <= 2 * r; k++)
                        if (i + k - r >= 0 && i + k - r < h)
                            sum += row_means[(i + k - r) % TAPS][j][ch];
                    res[ch] = 8'(sum / (2 * r + 1));
                end
                e.red = res[0];
                e.green = res[1];
                e.blue = res[2];
                e.last = (p == w * h - 1);
                blurred_q.push_back(e);
            end
        end
        if (t + 1 >= total)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        else
        begin
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] pix[CH_N];
        blurred_pixel_t e;
        if (!rst_n)
        begin
            width_reg = 1024;
            height_reg = 1024;
            radius_reg = 1;
            col_pos = 0;
            row_pos = 0;
            fail_count = 0;
            blurred_q.delete();
            for (int s = 0; s < TAPS; s++)
                for (int ch = 0; ch < CH_N; ch++)
                    row_window[s][ch] = '0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (blurred_q.size() == 0)
                begin
                    $error("unexpected output transaction");
                    fail_count++;
                end
                else
                begin
                    e = blurred_q.pop_front();
                    if (red_out !== e.red)
                    begin
                        $error("red_out expected %0d actual %0d", e.red, red_out);
                        fail_count++;
                    end
                    if (green_out !== e.green)
                    begin
                        $error("green_out expected %0d actual %0d", e.green, green_out);
                        fail_count++;
                    end
                    if (blue_out !== e.blue)
                    begin
                        $error("blue_out expected %0d actual %0d", e.blue, blue_out);
                        fail_count++;
                    end
                    if (frame_last !== e.last)
                    begin
                        $error("frame_last expected %0d actual %0d", e.last, frame_last);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT
                    || cfg_index == REG_RADIUS)
                begin
                    col_pos = 0;
                    row_pos = 0;
                end
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = cfg_data;
                else if (cfg_index == REG_RADIUS)
                    radius_reg = cfg_data[RAD_W-1:0];
            end
            if (in_valid && !in_stall)
            begin
                pix[0] = red_in;
                pix[1] = green_in;
                pix[2] = blue_in;
                blur_pixel(pix);
            end
        end
    end

endmodule

// File: tb/tb_separable_box_blur_top.sv
`timescale 1ns / 1ps

module tb_separable_box_blur_top;
    import sbb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           red_in = '0;
    logic [7:0]           green_in = '0;
    logic [7:0]           blue_in = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           red_out;
    logic [7:0]           green_out;
    logic [7:0]           blue_out;
    logic                 frame_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    int fail_count;
    int pending;
    int pixels_sent = 0;
    int send_idle_pct = 19;
    int stall_pct = 81;
    int idle_cycles = 0;
    bit hold_done = 1'b0;

    always #5 clk = ~clk;

    separable_box_blur_top DUT (.*);

    separable_box_blur_checker u_checker (.*);

    always @(posedge clk)
    begin
        if (rst_n && !hold_done && pixels_sent >= 700)
        begin
            hold_done = 1'b1;
            out_stall <= 1'b1;
            repeat (500) @(posedge clk);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= DIM_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int w, input int h, input int r);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_RADIUS, r);
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        if (pixels_sent < 600)
        begin
            send_idle_pct = 19;
            stall_pct = 81;
        end
        else if (pixels_sent < 1200)
        begin
            send_idle_pct = 81;
            stall_pct = 19;
        end
        else
        begin
            send_idle_pct = 0;
            stall_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic send_frame(input int w, input int h, input int r);
        int count;
        bit filtering;
        filtering = r >= 1 && r + 1 <= w / 2 && r + 1 <= h / 2;
        count = filtering ? w * h + r * w + r : w * h;
        for (int n = 0; n < count; n++)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        drain();
    endtask

    initial
    begin
        logic [7:0] pattern[4];
        int w;
        int h;
        int r;
        int max_r;
        pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_UNUSED, 2047);
        configure(4, 4, 1);
        for (int n = 0; n < 21; n++)
            send_pixel(pattern[n % 4], pattern[(n + 1) % 4], pattern[(n + 2) % 4]);
        drain();
        configure(0, 2047, 0);
        send_pixel(8'h00, 8'hFF, 8'h55);
        send_pixel(8'hFF, 8'h00, 8'hAA);
        drain();
        write_reg(REG_IMAGE_HEIGHT, 0);
        send_pixel(8'hAA, 8'h55, 8'h00);
        send_pixel(8'h55, 8'hAA, 8'hFF);
        drain();
        configure(2047, 1, 15);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        drain();

        while (pixels_sent < 1750)
        begin
            w = $urandom_range(12, 4);
            h = $urandom_range(10, 4);
            max_r = (w < h ? w : h) / 2 - 1;
            if ($urandom_range(99) < 80)
                r = $urandom_range(max_r, 1);
            else if ($urandom_range(1) == 0)
                r = 0;
            else
                r = $urandom_range(15, max_r + 1);
            configure(w, h, r);
            send_frame(w, h, r);
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: separable_box_blur_top.f
rtl/core/sbb_pkg.sv
rtl/core/sbb_ram.sv
rtl/core/sbb_div.sv
rtl/core/separable_box_blur_top.sv
tb/separable_box_blur_checker.sv
tb/tb_separable_box_blur_top.sv
